[design/swba_pkg.sv]
package swba_pkg;

    // Field and register widths.
    localparam int SAMPLE_BITS   = 12;
    localparam int COUNT_BITS    = 16;
    localparam int SUM_BITS      = SAMPLE_BITS + COUNT_BITS;
    localparam int WIN_BITS      = 16;
    localparam int VPB_BITS      = 20;
    localparam int VOLT_BITS     = 24;
    localparam int GAIN_BITS     = 20;
    localparam int FACTOR_BITS   = 20;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;

    // Shared multiplier operands and product.
    localparam int MUL_A_BITS = (SUM_BITS + 1 > GAIN_BITS) ? SUM_BITS + 1 : GAIN_BITS;
    localparam int MUL_B_BITS = (VPB_BITS + 1 > VOLT_BITS + 1) ? VPB_BITS + 1 : VOLT_BITS + 1;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

    // Divider: floor(sum * vpb / 16) divided by the count, 24 quotient bits.
    localparam int DIVIDEND_BITS = SUM_BITS + VPB_BITS - 4;
    localparam int QUOT_BITS     = VOLT_BITS;
    localparam int HI_BITS       = DIVIDEND_BITS - QUOT_BITS;
    localparam int CMP_BITS      = (HI_BITS > COUNT_BITS) ? HI_BITS : COUNT_BITS;
    localparam int ITER_BITS     = $clog2(QUOT_BITS);

    // Factor arithmetic after the shift by 16.
    localparam int FSUM_BITS = PROD_BITS - 15;
    localparam int ONE_Q16   = 65536;

    // Width for comparing counts with the window length.
    localparam int CW_BITS = (COUNT_BITS > WIN_BITS) ? COUNT_BITS : WIN_BITS;

    // Register reset values.
    localparam logic [WIN_BITS-1:0]  WINDOW_RST  = WIN_BITS'(1000);
    localparam logic [VPB_BITS-1:0]  VPB_RST     = VPB_BITS'(8651);
    localparam logic [VOLT_BITS-1:0] MIN_RST     = VOLT_BITS'(589824);
    localparam logic [GAIN_BITS-1:0] GAIN_RST    = '0;
    localparam logic [VOLT_BITS-1:0] NOMINAL_RST = VOLT_BITS'(720896);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WINDOW  = 3'd0,
        CFG_VPB     = 3'd1,
        CFG_MIN     = 3'd2,
        CFG_GAIN    = 3'd3,
        CFG_NOMINAL = 3'd4
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_MUL_AVG,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DIFF,
        ST_MUL_FAC,
        ST_FACTOR
    } t_state;

    // Divider control and status.
    typedef struct packed {
        logic start;
    } t_div_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[design/swba_in_if.sv]
interface swba_in_if;
    logic                             valid;
    logic                             ready;
    logic [swba_pkg::SAMPLE_BITS-1:0] adc_code;

    modport source (output valid, output adc_code, input ready);
    modport sink   (input valid, input adc_code, output ready);
endinterface

[design/swba_out_if.sv]
interface swba_out_if;
    logic                                    valid;
    logic                                    ready;
    logic [swba_pkg::VOLT_BITS-1:0]          average_volts;
    logic                                    battery_good;
    logic signed [swba_pkg::FACTOR_BITS-1:0] drive_factor;

    modport source (output valid, output average_volts, output battery_good,
                    output drive_factor, input ready);
    modport sink   (input valid, input average_volts, input battery_good,
                    input drive_factor, output ready);
endinterface

[design/swba_mul.sv]
module swba_mul (
    input  logic                                    i_clk,
    input  logic signed [swba_pkg::MUL_A_BITS-1:0]  i_a,
    input  logic signed [swba_pkg::MUL_B_BITS-1:0]  i_b,
    output logic signed [swba_pkg::PROD_BITS-1:0]   o_p
);

    logic signed [swba_pkg::PROD_BITS-1:0] r_p;

    // Signed product, registered before anyone uses it.
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

[design/swba_div.sv]
module swba_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  swba_pkg::t_div_ctrl                i_ctrl,
    input  logic [swba_pkg::DIVIDEND_BITS-1:0] i_dividend,
    input  logic [swba_pkg::COUNT_BITS-1:0]    i_divisor,
    output swba_pkg::t_div_stat                o_stat,
    output logic [swba_pkg::QUOT_BITS-1:0]     o_quotient
);

    logic [swba_pkg::COUNT_BITS-1:0] r_rem;
    logic [swba_pkg::QUOT_BITS-1:0]  r_q;
    logic [swba_pkg::ITER_BITS-1:0]  r_iter;
    logic                            r_busy;
    logic                            r_done;

    logic [swba_pkg::CMP_BITS-1:0]   hi_ext;
    logic [swba_pkg::CMP_BITS-1:0]   div_ext;
    logic                            sat;
    logic [swba_pkg::COUNT_BITS:0]   rem2;
    logic [swba_pkg::COUNT_BITS:0]   diff;
    logic                            ge;

    // A high part at or above the divisor means the quotient overflows 24 bits.
    assign hi_ext  = swba_pkg::CMP_BITS'(i_dividend[swba_pkg::DIVIDEND_BITS-1:swba_pkg::QUOT_BITS]);
    assign div_ext = swba_pkg::CMP_BITS'(i_divisor);
    assign sat     = hi_ext >= div_ext;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign rem2 = {r_rem, r_q[swba_pkg::QUOT_BITS-1]};
    assign diff = rem2 - {1'b0, i_divisor};
    assign ge   = rem2 >= {1'b0, i_divisor};

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else if (i_ctrl.start) begin
            r_busy <= !sat;
            r_done <= sat;
            r_iter <= '0;
        end else if (r_busy) begin
            r_iter <= r_iter + 1'b1;
            if (r_iter == swba_pkg::ITER_BITS'(swba_pkg::QUOT_BITS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_rem <= hi_ext[swba_pkg::COUNT_BITS-1:0];
            r_q   <= sat ? '1 : i_dividend[swba_pkg::QUOT_BITS-1:0];
        end else if (r_busy) begin
            r_rem <= ge ? diff[swba_pkg::COUNT_BITS-1:0] : rem2[swba_pkg::COUNT_BITS-1:0];
            r_q   <= {r_q[swba_pkg::QUOT_BITS-2:0], ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_q;

endmodule

[design/staggered_window_battery_average.sv]
// Battery monitor: each accepted 12-bit ADC beat is added into two block sums
// offset by half a window; the fuller sum gives the average voltage (Q8.16),
// the good flag (average above min_volts) and the drop compensation factor
// (signed Q4.16, zero when not good). After reset the first window_length/2
// beats only prime the first sum and give no result. Any other beat runs through
// the sum multiply, the 24-step serial divider that forms the average, the
// difference from nominal and the factor product; once its result is loaded the
// sequencer returns to idle and takes the next beat, and no beat is taken before
// then. An overflowing average skips the divider steps. One shared multiplier
// forms both the scaled sum and the factor product. A finished result waits in
// the output register while the next beat is taken; a result that finds the
// output register still full holds the sequencer until the register is read.
module staggered_window_battery_average (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [swba_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [swba_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    swba_in_if.sink                             i_sample,
    swba_out_if.source                          o_result
);

    // Configuration registers.
    logic [swba_pkg::WIN_BITS-1:0]         r_window;
    logic [swba_pkg::VPB_BITS-1:0]         r_vpb;
    logic [swba_pkg::VOLT_BITS-1:0]        r_min;
    logic signed [swba_pkg::GAIN_BITS-1:0] r_gain;
    logic [swba_pkg::VOLT_BITS-1:0]        r_nominal;

    // Window state.
    logic [swba_pkg::SUM_BITS-1:0]   r_sum_first, n_sum_first;
    logic [swba_pkg::SUM_BITS-1:0]   r_sum_second, n_sum_second;
    logic [swba_pkg::COUNT_BITS-1:0] r_cnt_first, n_cnt_first;
    logic [swba_pkg::COUNT_BITS-1:0] r_cnt_second, n_cnt_second;
    logic                            r_priming;

    // Working registers.
    swba_pkg::t_state                        r_state, n_state;
    logic [swba_pkg::SAMPLE_BITS-1:0]        r_sample;
    logic [swba_pkg::SUM_BITS-1:0]           r_sel_sum;
    logic [swba_pkg::COUNT_BITS-1:0]         r_sel_cnt;
    logic [swba_pkg::VOLT_BITS-1:0]          r_avg;
    logic signed [swba_pkg::VOLT_BITS:0]     r_diff;

    // Output register.
    logic                                    r_out_valid;
    logic [swba_pkg::VOLT_BITS-1:0]          r_out_avg;
    logic                                    r_out_good;
    logic signed [swba_pkg::FACTOR_BITS-1:0] r_out_factor;

    // Shared units.
    logic signed [swba_pkg::MUL_A_BITS-1:0]  mul_a;
    logic signed [swba_pkg::MUL_B_BITS-1:0]  mul_b;
    logic signed [swba_pkg::PROD_BITS-1:0]   prod;
    swba_pkg::t_div_ctrl                     div_ctrl;
    swba_pkg::t_div_stat                     div_stat;
    logic [swba_pkg::QUOT_BITS-1:0]          quotient;

    // Update arithmetic.
    logic [swba_pkg::CW_BITS-1:0]            cf_ext, cs_ext, win_ext, half_ext;
    logic                                    prime_now;
    logic                                    clr_first, clr_second;
    logic [swba_pkg::SUM_BITS-1:0]           sample_ext;

    // Factor arithmetic.
    logic signed [swba_pkg::FSUM_BITS-1:0]   fac_sum;
    logic signed [swba_pkg::FACTOR_BITS-1:0] fac_sat;
    logic                                    good;
    logic                                    out_free;
    logic                                    load_out;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= swba_pkg::WINDOW_RST;
            r_vpb     <= swba_pkg::VPB_RST;
            r_min     <= swba_pkg::MIN_RST;
            r_gain    <= swba_pkg::GAIN_RST;
            r_nominal <= swba_pkg::NOMINAL_RST;
        end else if (i_cfg_we) begin
            unique case (swba_pkg::t_cfg_idx'(i_cfg_idx))
                swba_pkg::CFG_WINDOW:  r_window  <= i_cfg_data[swba_pkg::WIN_BITS-1:0];
                swba_pkg::CFG_VPB:     r_vpb     <= i_cfg_data[swba_pkg::VPB_BITS-1:0];
                swba_pkg::CFG_MIN:     r_min     <= i_cfg_data[swba_pkg::VOLT_BITS-1:0];
                swba_pkg::CFG_GAIN:    r_gain    <= i_cfg_data[swba_pkg::GAIN_BITS-1:0];
                swba_pkg::CFG_NOMINAL: r_nominal <= i_cfg_data[swba_pkg::VOLT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Window bookkeeping: priming check, window wrap and sample add.
    assign cf_ext     = swba_pkg::CW_BITS'(r_cnt_first);
    assign cs_ext     = swba_pkg::CW_BITS'(r_cnt_second);
    assign win_ext    = swba_pkg::CW_BITS'(r_window);
    assign half_ext   = swba_pkg::CW_BITS'(r_window >> 1);
    assign prime_now  = r_priming && (cf_ext < half_ext);
    assign clr_first  = (cf_ext >= win_ext) || (r_cnt_first == '1);
    assign clr_second = (cs_ext >= win_ext) || (r_cnt_second == '1);
    assign sample_ext = swba_pkg::SUM_BITS'(r_sample);

    always_comb begin
        if (prime_now) begin
            n_sum_first  = r_sum_first + sample_ext;
            n_cnt_first  = r_cnt_first + 1'b1;
            n_sum_second = r_sum_second;
            n_cnt_second = r_cnt_second;
        end else begin
            n_sum_first  = (clr_first ? '0 : r_sum_first) + sample_ext;
            n_cnt_first  = (clr_first ? '0 : r_cnt_first) + 1'b1;
            n_sum_second = (clr_second ? '0 : r_sum_second) + sample_ext;
            n_cnt_second = (clr_second ? '0 : r_cnt_second) + 1'b1;
        end
    end

    // Shared multiplier operands: scaled sum first, then the factor product.
    // The factor operands stay selected while the result waits for the output
    // register, so the registered product holds still.
    always_comb begin
        if (r_state == swba_pkg::ST_MUL_FAC || r_state == swba_pkg::ST_FACTOR) begin
            mul_a = swba_pkg::MUL_A_BITS'(r_gain);
            mul_b = swba_pkg::MUL_B_BITS'(r_diff);
        end else begin
            mul_a = $signed(swba_pkg::MUL_A_BITS'(r_sel_sum));
            mul_b = $signed(swba_pkg::MUL_B_BITS'(r_vpb));
        end
    end

    swba_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    swba_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (div_ctrl),
        .i_dividend (prod[swba_pkg::SUM_BITS+swba_pkg::VPB_BITS-1:4]),
        .i_divisor  (r_sel_cnt),
        .o_stat     (div_stat),
        .o_quotient (quotient)
    );

    // Factor: one plus the floored product over 2^16, clamped to 20 bits.
    assign fac_sum = swba_pkg::FSUM_BITS'($signed(prod[swba_pkg::PROD_BITS-1:16]))
                     + swba_pkg::FSUM_BITS'(swba_pkg::ONE_Q16);
    always_comb begin
        priority if (fac_sum > swba_pkg::FSUM_BITS'(signed'(2 ** (swba_pkg::FACTOR_BITS - 1) - 1)))
            fac_sat = {1'b0, {(swba_pkg::FACTOR_BITS - 1){1'b1}}};
        else if (fac_sum < -swba_pkg::FSUM_BITS'(signed'(2 ** (swba_pkg::FACTOR_BITS - 1))))
            fac_sat = {1'b1, {(swba_pkg::FACTOR_BITS - 1){1'b0}}};
        else
            fac_sat = fac_sum[swba_pkg::FACTOR_BITS-1:0];
    end

    assign good     = r_avg > r_min;
    assign out_free = !r_out_valid || o_result.ready;

    // Sequencer: next state and unit controls.
    always_comb begin
        n_state        = r_state;
        div_ctrl.start = 1'b0;
        load_out       = 1'b0;
        unique case (r_state)
            swba_pkg::ST_IDLE: begin
                if (i_sample.valid) n_state = swba_pkg::ST_UPDATE;
            end
            swba_pkg::ST_UPDATE: begin
                n_state = prime_now ? swba_pkg::ST_IDLE : swba_pkg::ST_MUL_AVG;
            end
            swba_pkg::ST_MUL_AVG: begin
                n_state = swba_pkg::ST_DIV_GO;
            end
            swba_pkg::ST_DIV_GO: begin
                div_ctrl.start = 1'b1;
                n_state        = swba_pkg::ST_DIV_WAIT;
            end
            swba_pkg::ST_DIV_WAIT: begin
                if (div_stat.done) n_state = swba_pkg::ST_DIFF;
            end
            swba_pkg::ST_DIFF: begin
                n_state = swba_pkg::ST_MUL_FAC;
            end
            swba_pkg::ST_MUL_FAC: begin
                n_state = swba_pkg::ST_FACTOR;
            end
            swba_pkg::ST_FACTOR: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = swba_pkg::ST_IDLE;
                end
            end
            default: n_state = swba_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swba_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Window state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_first  <= '0;
            r_sum_second <= '0;
            r_cnt_first  <= '0;
            r_cnt_second <= '0;
            r_priming    <= 1'b1;
        end else if (r_state == swba_pkg::ST_UPDATE) begin
            r_sum_first  <= n_sum_first;
            r_sum_second <= n_sum_second;
            r_cnt_first  <= n_cnt_first;
            r_cnt_second <= n_cnt_second;
            r_priming    <= prime_now;
        end
    end

    // Working registers along the sequence.
    always_ff @(posedge i_clk) begin
        if (r_state == swba_pkg::ST_IDLE && i_sample.valid) begin
            r_sample <= i_sample.adc_code;
        end
        if (r_state == swba_pkg::ST_UPDATE) begin
            if (n_cnt_second > n_cnt_first) begin
                r_sel_sum <= n_sum_second;
                r_sel_cnt <= n_cnt_second;
            end else begin
                r_sel_sum <= n_sum_first;
                r_sel_cnt <= n_cnt_first;
            end
        end
        if (r_state == swba_pkg::ST_DIV_WAIT && div_stat.done) begin
            r_avg <= quotient;
        end
        if (r_state == swba_pkg::ST_DIFF) begin
            r_diff <= $signed({1'b0, r_avg}) - $signed({1'b0, r_nominal});
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_avg    <= r_avg;
            r_out_good   <= good;
            r_out_factor <= good ? fac_sat : '0;
        end
    end

    assign i_sample.ready         = (r_state == swba_pkg::ST_IDLE);
    assign o_result.valid         = r_out_valid;
    assign o_result.average_volts = r_out_avg;
    assign o_result.battery_good  = r_out_good;
    assign o_result.drive_factor  = r_out_factor;

    // An accepted beat always moves on to the window update.
    a_accept_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready) |=> (r_state == swba_pkg::ST_UPDATE))
        else $error("accepted beat did not start the window update");

    // Once priming is over, both counts are nonzero, so the divisor is never zero.
    a_counts_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == swba_pkg::ST_UPDATE) |=>
            (r_priming || (r_cnt_first != '0 && r_cnt_second != '0)))
        else $error("a count is zero after a normal update");

    // The divider only reports completion while the sequencer waits for it.
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == swba_pkg::ST_DIV_WAIT))
        else $error("divider finished outside the wait state");

    // A result without a good battery carries a zero factor.
    a_factor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_good) |-> (r_out_factor == '0))
        else $error("nonzero factor on a bad battery result");

endmodule

[test/staggered_window_battery_average_test.sv]
`timescale 1ns / 100ps

module staggered_window_battery_average_test;

    import swba_pkg::*;

    // Register values the block must come out of reset with.
    localparam logic [WIN_BITS-1:0]         WINDOW_AT_RESET  = 16'd1000;
    localparam logic [VPB_BITS-1:0]         VPB_AT_RESET     = 20'd8651;
    localparam logic [VOLT_BITS-1:0]        MIN_AT_RESET     = 24'd589824;
    localparam logic signed [GAIN_BITS-1:0] GAIN_AT_RESET    = 20'sd0;
    localparam logic [VOLT_BITS-1:0]        NOMINAL_AT_RESET = 24'd720896;

    // Settling wait after the last reading, long enough for a priming beat to finish.
    localparam int SETTLE_CYCLES = 64;
    localparam int QUIET_LIMIT   = 2000;
    localparam int MAX_WAIT      = 9;

    typedef struct {
        logic [VOLT_BITS-1:0]          avg;
        logic                          good;
        logic signed [FACTOR_BITS-1:0] factor;
    } t_reading;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    swba_in_if  sample_if ();
    swba_out_if result_if ();

    staggered_window_battery_average dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (sample_if),
        .o_result   (result_if)
    );

    // Readings still owed by the block, oldest first.
    t_reading pending_readings[$];
    int       error_count  = 0;
    int       quiet_cycles = 0;
    bit       sender_calm  = 0;
    bit       sink_calm    = 0;

    // Own copy of the averaging state and the registers.
    logic [SUM_BITS-1:0]          win_sum_a      = '0;
    logic [SUM_BITS-1:0]          win_sum_b      = '0;
    logic [COUNT_BITS-1:0]        win_cnt_a      = '0;
    logic [COUNT_BITS-1:0]        win_cnt_b      = '0;
    bit                           priming_active = 1'b1;
    logic [WIN_BITS-1:0]          set_window     = WINDOW_AT_RESET;
    logic [VPB_BITS-1:0]          set_vpb        = VPB_AT_RESET;
    logic [VOLT_BITS-1:0]         set_min        = MIN_AT_RESET;
    logic signed [GAIN_BITS-1:0]  set_gain       = GAIN_AT_RESET;
    logic [VOLT_BITS-1:0]         set_nominal    = NOMINAL_AT_RESET;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_error(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Wait drawn per beat; now and then a side switches between idling and streaming.
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 24) == 0) begin
            calm = !calm;
        end
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Advance the window state by one sample and work out the reading it gives.
    function automatic bit predict_reading(input logic [SAMPLE_BITS-1:0] code,
                                           output t_reading r);
        logic [SUM_BITS-1:0]   sum_sel;
        logic [COUNT_BITS-1:0] cnt_sel;
        logic [63:0]           scaled;
        logic [63:0]           divisor;
        logic [63:0]           quot;
        logic signed [63:0]    diff;
        logic signed [63:0]    slope;
        logic signed [63:0]    factor;
        r.avg    = '0;
        r.good   = 1'b0;
        r.factor = '0;

        // Priming fills only the first sum until it holds half a window.
        if (priming_active && win_cnt_a >= (set_window >> 1)) begin
            priming_active = 1'b0;
        end
        if (priming_active) begin
            win_sum_a = win_sum_a + SUM_BITS'(code);
            win_cnt_a = win_cnt_a + 1'b1;
            return 1'b0;
        end

        // A full window, or a count at its top, starts over.
        if (win_cnt_a >= set_window || win_cnt_a == '1) begin
            win_cnt_a = '0;
            win_sum_a = '0;
        end
        if (win_cnt_b >= set_window || win_cnt_b == '1) begin
            win_cnt_b = '0;
            win_sum_b = '0;
        end
        win_sum_a = win_sum_a + SUM_BITS'(code);
        win_sum_b = win_sum_b + SUM_BITS'(code);
        win_cnt_a = win_cnt_a + 1'b1;
        win_cnt_b = win_cnt_b + 1'b1;

        // The fuller window wins; the first one on a tie.
        if (win_cnt_b > win_cnt_a) begin
            sum_sel = win_sum_b;
            cnt_sel = win_cnt_b;
        end else begin
            sum_sel = win_sum_a;
            cnt_sel = win_cnt_a;
        end
        scaled  = 64'(sum_sel) * 64'(set_vpb);
        divisor = 64'(cnt_sel) << 4;
        quot    = scaled / divisor;
        r.avg   = (quot > 64'(24'hFFFFFF)) ? '1 : quot[VOLT_BITS-1:0];
        r.good  = r.avg > set_min;

        // Drop compensation, floored after the Q16 product and clamped to Q4.16.
        if (r.good) begin
            diff   = $signed(64'(r.avg)) - $signed(64'(set_nominal));
            slope  = 64'(set_gain);
            factor = 64'sd65536 + ((diff * slope) >>> 16);
            if (factor > 64'sd524287) begin
                factor = 64'sd524287;
            end else if (factor < -64'sd524288) begin
                factor = -64'sd524288;
            end
            r.factor = factor[FACTOR_BITS-1:0];
        end
        return 1'b1;
    endfunction

    // Send one sample beat after a random gap; valid stays up for a back-to-back beat.
    task automatic send_code(input logic [SAMPLE_BITS-1:0] code);
        t_reading r;
        int       gap;
        gap = draw_wait(sender_calm);
        if (gap > 0) begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (predict_reading(code, r)) begin
            pending_readings.push_back(r);
        end
        sample_if.valid    <= 1'b1;
        sample_if.adc_code <= code;
        do @(posedge i_clk); while (!sample_if.ready);
    endtask

    // Stop sending until every owed reading has come back.
    task automatic hold_off();
        sample_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_readings.size() != 0);
    endtask

    // Stop sending, collect every reading, then let a silent beat finish.
    task automatic wait_idle();
        sample_if.valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Write all five registers while the block is idle.
    task automatic load_settings(input logic [WIN_BITS-1:0] win,
                                 input logic [VPB_BITS-1:0] vpb,
                                 input logic [VOLT_BITS-1:0] min_v,
                                 input logic signed [GAIN_BITS-1:0] gain,
                                 input logic [VOLT_BITS-1:0] nom);
        wait_idle();
        put_reg(CFG_WINDOW, CFG_DATA_BITS'(win));
        put_reg(CFG_VPB, CFG_DATA_BITS'(vpb));
        put_reg(CFG_MIN, CFG_DATA_BITS'(min_v));
        put_reg(CFG_GAIN, CFG_DATA_BITS'(gain));
        put_reg(CFG_NOMINAL, CFG_DATA_BITS'(nom));
        i_cfg_we    <= 1'b0;
        set_window  = win;
        set_vpb     = vpb;
        set_min     = min_v;
        set_gain    = gain;
        set_nominal = nom;
    endtask

    // A threshold or nominal level around the average that typical codes give, or zero or full scale.
    function automatic logic [VOLT_BITS-1:0] pick_level(input logic [31:0] level);
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                v = $urandom_range(0, level + level / 2);
                return (v > 32'hFFFFFF) ? '1 : v[VOLT_BITS-1:0];
            end
        endcase
    endfunction

    // Uniform codes, a tight cluster, or mostly the rails.
    function automatic logic [SAMPLE_BITS-1:0] pick_code(input int style, input int center);
        int v;
        case (style)
            2: begin
                v = center + $urandom_range(0, 64) - 32;
                if (v < 0) begin
                    v = 0;
                end else if (v > 4095) begin
                    v = 4095;
                end
                return v[SAMPLE_BITS-1:0];
            end
            3: begin
                if ($urandom_range(0, 2) == 0) begin
                    return SAMPLE_BITS'($urandom_range(0, 4095));
                end
                return $urandom_range(0, 1) ? '1 : '0;
            end
            default: begin
                return SAMPLE_BITS'($urandom_range(0, 4095));
            end
        endcase
    endfunction

    // Reset values: half the default window primes silently, then readings follow.
    task automatic test_reset_priming();
        repeat (515) send_code(SAMPLE_BITS'($urandom_range(0, 4095)));
    endtask

    // Zero and one sample windows, codes at the rails and the strict threshold.
    task automatic test_zero_window_threshold();
        load_settings(16'd0, 20'd16, 24'd100, 20'sd0, 24'd0);
        send_code(12'd0);
        send_code(12'd4095);
        send_code(12'd100);
        send_code(12'd101);
        send_code(12'd99);
        // A gain of minus one shows the floor of a small negative product.
        load_settings(16'd1, 20'd16, 24'd100, -20'sd1, 24'd200);
        send_code(12'd101);
        send_code(12'd4095);
        send_code(12'd100);
    endtask

    // Average and factor saturation in both directions.
    task automatic test_saturation();
        load_settings(16'd1, 20'hFFFFF, 24'hFFFFFF, 20'sh7FFFF, 24'd0);
        send_code(12'd4095);
        send_code(12'd0);
        load_settings(16'd1, 20'hFFFFF, 24'd0, 20'sh7FFFF, 24'd0);
        send_code(12'd4095);
        send_code(12'd1);
        send_code(12'd0);
        load_settings(16'd1, 20'hFFFFF, 24'd0, -20'sh80000, 24'd0);
        send_code(12'd4095);
        load_settings(16'd1, 20'd16, 24'd0, 20'sh7FFFF, 24'hFFFFFF);
        send_code(12'd1);
        send_code(12'd0);
        load_settings(16'd1, 20'd16, 24'd0, -20'sh80000, 24'hFFFFFF);
        send_code(12'd1);
        send_code(12'd2048);
    endtask

    // The widest window, then shorter ones that cut the running sums.
    task automatic test_window_changes();
        load_settings(16'hFFFF, 20'd8651, 24'd589824, -20'sd20000, 24'd786432);
        repeat (40) send_code(SAMPLE_BITS'($urandom_range(0, 4095)));
        load_settings(16'd3, 20'd8651, 24'd589824, 20'sd30000, 24'd720896);
        repeat (15) send_code(SAMPLE_BITS'($urandom_range(0, 4095)));
        load_settings(16'd2, 20'd9000, 24'd500000, 20'sd65536, 24'd700000);
        repeat (10) send_code(SAMPLE_BITS'($urandom_range(0, 4095)));
    endtask

    // The sender waits for each reading before the next beat.
    task automatic test_one_at_a_time();
        load_settings(16'd7, 20'd8651, 24'd600000, -20'sd40000, 24'd720896);
        repeat (20) begin
            hold_off();
            send_code(SAMPLE_BITS'($urandom_range(0, 4095)));
        end
    endtask

    // Random settings per phase, with windows mostly short so the sums turn over.
    task automatic test_random_settings(input int n_items);
        logic [WIN_BITS-1:0]         win;
        logic [VPB_BITS-1:0]         vpb;
        logic signed [GAIN_BITS-1:0] gain;
        logic [31:0]                 level;
        int                          sent;
        int                          phase_len;
        int                          style;
        int                          center;
        int                          offset;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 9))
                0: win = '0;
                1: win = 16'd1;
                7: win = WIN_BITS'($urandom_range(13, 64));
                8: win = WIN_BITS'($urandom_range(65, 300));
                9: win = WIN_BITS'($urandom);
                default: win = WIN_BITS'($urandom_range(2, 12));
            endcase
            case ($urandom_range(0, 7))
                0: vpb = '0;
                1: vpb = '1;
                2: vpb = VPB_BITS'($urandom);
                default: vpb = VPB_BITS'($urandom_range(4000, 16000));
            endcase
            case ($urandom_range(0, 7))
                0: gain = -20'sh80000;
                1: gain = 20'sh7FFFF;
                2: begin
                    offset = $urandom_range(0, 131071);
                    gain   = 20'(offset - 65536);
                end
                default: gain = GAIN_BITS'($urandom);
            endcase
            level = 32'(vpb) << 7;
            load_settings(win, vpb, pick_level(level), gain, pick_level(level));
            style     = $urandom_range(0, 3);
            center    = $urandom_range(0, 4095);
            phase_len = $urandom_range(30, 80);
            repeat (phase_len) send_code(pick_code(style, center));
            sent += phase_len;
        end
    endtask

    // Result side: a random stall before each beat, then ready until it is taken.
    initial begin
        result_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            int stall;
            stall = draw_wait(sink_calm);
            if (stall > 0) begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(result_if.valid && result_if.ready));
        end
    end

    // Compare every result beat with the oldest owed reading.
    always @(posedge i_clk) begin : check_readings
        t_reading want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (pending_readings.size() == 0) begin
                report_error("result beat with no reading owed");
            end else begin
                want = pending_readings.pop_front();
                if (result_if.average_volts !== want.avg) begin
                    report_error($sformatf("average_volts got %0d, expected %0d",
                                           result_if.average_volts, want.avg));
                end
                if (result_if.battery_good !== want.good) begin
                    report_error($sformatf("battery_good got %0b, expected %0b",
                                           result_if.battery_good, want.good));
                end
                if (result_if.drive_factor !== want.factor) begin
                    report_error($sformatf("drive_factor got %0d, expected %0d",
                                           result_if.drive_factor, want.factor));
                end
            end
        end
    end

    // End the run when nothing moves on any port for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (sample_if.valid && sample_if.ready)
                || (result_if.valid && result_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("staggered_window_battery_average_test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_WINDOW;
        i_cfg_data         <= '0;
        sample_if.valid    <= 1'b0;
        sample_if.adc_code <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_priming();
        test_zero_window_threshold();
        test_saturation();
        test_window_changes();
        test_one_at_a_time();
        test_random_settings(280);

        wait_idle();
        if (pending_readings.size() != 0) begin
            report_error("readings still owed at the end of the run");
        end
        if (error_count == 0) begin
            $display("staggered_window_battery_average_test passed");
        end else begin
            $display("staggered_window_battery_average_test failed");
        end
        $finish;
    end

endmodule
